>>> rtl/sampled_curve_interpolator_core_macros.svh
// ----------------------------------------------------------------------------
// Sampled curve interpolator assertion macros
// Concurrent check shorthands, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLED_CURVE_INTERPOLATOR_CORE_MACROS_SVH
`define SAMPLED_CURVE_INTERPOLATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCIP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scip: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SCIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scip: next-cycle check failed");

`endif

>>> rtl/scip_pkg.sv
// ----------------------------------------------------------------------------
// scip_pkg
// Shared sizes, codes and types of the sampled curve interpolator.
// ----------------------------------------------------------------------------
package scip_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

    localparam int WL_W       = 16;
    localparam int SAMPLE_W   = 16;
    localparam int INT_W      = 15;
    localparam int ENTRY_W    = WL_W + INT_W;
    localparam int PROD_W     = WL_W + INT_W;
    localparam int SUM_W      = INT_W + 2;
    localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

    localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

    // Request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_NO_SPECTRUM  = 2'd1;
    localparam logic [1:0] STAT_OUT_OF_ORDER = 2'd2;
    localparam logic [1:0] STAT_FULL         = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_HI_RD,
        ST_HI_CHK,
        ST_LO_RD,
        ST_LO_CHK,
        ST_MUL,
        ST_DSTART,
        ST_DIV
    } scip_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/scip_ram.sv
// ----------------------------------------------------------------------------
// scip_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module scip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/scip_div.sv
// ----------------------------------------------------------------------------
// scip_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scip_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [scip_pkg::PROD_W-1:0]  dividend,
    input  logic [scip_pkg::WL_W-1:0]    divisor,
    output logic [scip_pkg::PROD_W-1:0]  quotient,
    output scip_pkg::div_stat_t          stat
);

    logic [scip_pkg::WL_W-1:0]      rem_reg, rem_next;
    logic [scip_pkg::PROD_W-1:0]    quo_reg, quo_next;
    logic [scip_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [scip_pkg::WL_W:0] trial;
    logic [scip_pkg::WL_W:0] diff;
    logic                    fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[scip_pkg::PROD_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = scip_pkg::DIV_CNT_W'(scip_pkg::PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract if the divisor fits
            rem_next = fits ? diff[scip_pkg::WL_W-1:0] : trial[scip_pkg::WL_W-1:0];
            quo_next = {quo_reg[scip_pkg::PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == scip_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> rtl/sampled_curve_interpolator_core.sv
// ----------------------------------------------------------------------------
// sampled_curve_interpolator_core
// Piecewise linear breakpoint table with binary search and serial division.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low. Every beat gives
// exactly one result, shown on intensity_out and status for one cycle with
// done high; the receiver cannot stall, so capture it on that cycle. Clear,
// load, unused codes and queries that resolve without searching (empty or
// all-zero table, wavelength at or beyond either end) answer at once: the
// result appears in the next cycle and busy stays low, so such beats may
// follow each other in every cycle. A query that falls inside the table
// holds busy high through a binary search of S steps, where S is at most
// ceil(log2(point count + 1)), 7 for a full 64-entry table; each step costs
// a table read and a compare on the single RAM read port. Two more reads, a
// multiply and the bit-serial divider (31 quotient bits) follow. A query
// that lands exactly on a breakpoint stops after the search and one more
// read. The result of a searching query appears in the first cycle with
// busy low. Breakpoints sit in one RAM of wavelength and intensity; the
// first and last breakpoints are also held in registers for the end
// checks. The RAM needs no clearing pass: only entries below the fill
// count are ever read.
// ----------------------------------------------------------------------------
`include "sampled_curve_interpolator_core_macros.svh"

module sampled_curve_interpolator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [1:0]                          req_type,
    input  logic [scip_pkg::WL_W-1:0]           wavelength,
    input  logic signed [scip_pkg::SAMPLE_W-1:0] sample_intensity,
    output logic                                busy,
    output logic                                done,
    output logic [scip_pkg::INT_W-1:0]          intensity_out,
    output logic [1:0]                          status
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    scip_pkg::scip_state_t state_reg, state_next;

    logic [scip_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         any_pos_reg, any_pos_next;
    logic                         done_reg, done_next;

    logic [scip_pkg::WL_W-1:0]    first_wl_reg, first_wl_next;
    logic [scip_pkg::INT_W-1:0]   first_int_reg, first_int_next;
    logic [scip_pkg::WL_W-1:0]    last_wl_reg, last_wl_next;
    logic [scip_pkg::INT_W-1:0]   last_int_reg, last_int_next;

    // query working registers
    logic [scip_pkg::WL_W-1:0]    q_wl_reg, q_wl_next;
    logic [scip_pkg::COUNT_W-1:0] lo_reg, lo_next;
    logic [scip_pkg::COUNT_W-1:0] hi_reg, hi_next;
    logic [scip_pkg::WL_W-1:0]    w1_reg, w1_next;
    logic [scip_pkg::INT_W-1:0]   i1_reg, i1_next;
    logic [scip_pkg::INT_W-1:0]   i0_reg, i0_next;
    logic [scip_pkg::WL_W-1:0]    dw_reg, dw_next;
    logic [scip_pkg::WL_W-1:0]    width_reg, width_next;
    logic [scip_pkg::INT_W-1:0]   dmag_reg, dmag_next;
    logic                         neg_reg, neg_next;
    logic [scip_pkg::PROD_W-1:0]  prod_reg, prod_next;

    // result registers
    logic [scip_pkg::INT_W-1:0]   int_out_reg, int_out_next;
    logic [1:0]                   status_reg, status_next;

    // ------------------------------------------------------------------
    // Breakpoint RAM and divider
    // ------------------------------------------------------------------
    logic                          ram_we;
    logic [scip_pkg::ADDR_W-1:0]   ram_waddr;
    logic [scip_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [scip_pkg::ADDR_W-1:0]   ram_raddr;
    logic [scip_pkg::ENTRY_W-1:0]  ram_rdata;

    logic                          div_start;
    logic [scip_pkg::PROD_W-1:0]   div_quo;
    scip_pkg::div_stat_t           div_stat;

    scip_ram #(
        .WIDTH (scip_pkg::ENTRY_W),
        .DEPTH (scip_pkg::MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scip_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (width_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [scip_pkg::INT_W-1:0]   load_mag;
    logic [scip_pkg::COUNT_W-1:0] mid;
    logic [scip_pkg::COUNT_W-1:0] lo_m1;
    logic [scip_pkg::COUNT_W-1:0] lo_tmp;
    logic [scip_pkg::COUNT_W-1:0] hi_tmp;
    logic [scip_pkg::WL_W-1:0]    rd_wl;
    logic [scip_pkg::INT_W-1:0]   rd_int;
    logic [scip_pkg::WL_W-1:0]    di;
    logic [scip_pkg::WL_W-1:0]    di_abs;
    logic [scip_pkg::INT_W-1:0]   q15;
    logic [scip_pkg::SUM_W-1:0]   r_sum;

    always_comb
    begin
        // negative samples store as zero
        load_mag = sample_intensity[scip_pkg::SAMPLE_W-1] ? '0
                                                           : sample_intensity[scip_pkg::INT_W-1:0];
        mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
        lo_m1  = lo_reg - 1'b1;
        rd_wl  = ram_rdata[scip_pkg::ENTRY_W-1:scip_pkg::INT_W];
        rd_int = ram_rdata[scip_pkg::INT_W-1:0];
        di     = {1'b0, i1_reg} - {1'b0, rd_int};
        di_abs = di[scip_pkg::WL_W-1] ? (~di + 1'b1) : di;
        q15    = div_quo[scip_pkg::INT_W-1:0];
        r_sum  = neg_reg ? ({2'b00, i0_reg} - {2'b00, q15})
                         : ({2'b00, i0_reg} + {2'b00, q15});
        lo_tmp = lo_reg;
        hi_tmp = hi_reg;

        state_next     = state_reg;
        count_next     = count_reg;
        any_pos_next   = any_pos_reg;
        done_next      = 1'b0;
        first_wl_next  = first_wl_reg;
        first_int_next = first_int_reg;
        last_wl_next   = last_wl_reg;
        last_int_next  = last_int_reg;
        q_wl_next      = q_wl_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        w1_next        = w1_reg;
        i1_next        = i1_reg;
        i0_next        = i0_reg;
        dw_next        = dw_reg;
        width_next     = width_reg;
        dmag_next      = dmag_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        int_out_next   = int_out_reg;
        status_next    = status_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[scip_pkg::ADDR_W-1:0];
        ram_wdata = {wavelength, load_mag};
        ram_raddr = mid[scip_pkg::ADDR_W-1:0];
        div_start = 1'b0;

        unique case (state_reg)
            scip_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // most beats answer at once; default to a zero ok result
                    done_next    = 1'b1;
                    int_out_next = '0;
                    status_next  = scip_pkg::STAT_OK;
                    unique case (req_type)
                        scip_pkg::REQ_CLEAR:
                        begin
                            count_next   = '0;
                            any_pos_next = 1'b0;
                        end
                        scip_pkg::REQ_LOAD:
                        begin
                            if (count_reg >= scip_pkg::COUNT_W'(scip_pkg::MAX_POINTS))
                            begin
                                status_next = scip_pkg::STAT_FULL;
                            end
                            else if (count_reg != '0 && wavelength <= last_wl_reg)
                            begin
                                status_next = scip_pkg::STAT_OUT_OF_ORDER;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (count_reg == '0)
                                begin
                                    first_wl_next  = wavelength;
                                    first_int_next = load_mag;
                                end
                                last_wl_next  = wavelength;
                                last_int_next = load_mag;
                                count_next    = count_reg + 1'b1;
                                if (load_mag != '0)
                                begin
                                    any_pos_next = 1'b1;
                                end
                            end
                        end
                        scip_pkg::REQ_QUERY:
                        begin
                            if (count_reg == '0 || !any_pos_reg)
                            begin
                                status_next = scip_pkg::STAT_NO_SPECTRUM;
                            end
                            else if (wavelength <= first_wl_reg)
                            begin
                                int_out_next = first_int_reg;
                            end
                            else if (wavelength >= last_wl_reg)
                            begin
                                int_out_next = last_int_reg;
                            end
                            else
                            begin
                                // strictly inside: search for the upper bracket
                                done_next  = 1'b0;
                                q_wl_next  = wavelength;
                                lo_next    = '0;
                                hi_next    = count_reg;
                                state_next = scip_pkg::ST_SRCH_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            scip_pkg::ST_SRCH_RD:
            begin
                state_next = scip_pkg::ST_SRCH_CMP;
            end

            scip_pkg::ST_SRCH_CMP:
            begin
                if (rd_wl < q_wl_reg)
                begin
                    lo_tmp = mid + 1'b1;
                end
                else
                begin
                    hi_tmp = mid;
                end
                lo_next    = lo_tmp;
                hi_next    = hi_tmp;
                state_next = (lo_tmp < hi_tmp) ? scip_pkg::ST_SRCH_RD : scip_pkg::ST_HI_RD;
            end

            scip_pkg::ST_HI_RD:
            begin
                ram_raddr  = lo_reg[scip_pkg::ADDR_W-1:0];
                state_next = scip_pkg::ST_HI_CHK;
            end

            scip_pkg::ST_HI_CHK:
            begin
                if (rd_wl == q_wl_reg)
                begin
                    // exact hit
                    int_out_next = rd_int;
                    status_next  = scip_pkg::STAT_OK;
                    done_next    = 1'b1;
                    state_next   = scip_pkg::ST_IDLE;
                end
                else
                begin
                    w1_next    = rd_wl;
                    i1_next    = rd_int;
                    state_next = scip_pkg::ST_LO_RD;
                end
            end

            scip_pkg::ST_LO_RD:
            begin
                ram_raddr  = lo_m1[scip_pkg::ADDR_W-1:0];
                state_next = scip_pkg::ST_LO_CHK;
            end

            scip_pkg::ST_LO_CHK:
            begin
                i0_next    = rd_int;
                dw_next    = q_wl_reg - rd_wl;
                width_next = w1_reg - rd_wl;
                neg_next   = di[scip_pkg::WL_W-1];
                dmag_next  = di_abs[scip_pkg::INT_W-1:0];
                state_next = scip_pkg::ST_MUL;
            end

            scip_pkg::ST_MUL:
            begin
                prod_next  = dw_reg * dmag_reg;
                state_next = scip_pkg::ST_DSTART;
            end

            scip_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = scip_pkg::ST_DIV;
            end

            scip_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    // apply the signed step and clamp to the output range
                    if (r_sum[scip_pkg::SUM_W-1])
                    begin
                        int_out_next = '0;
                    end
                    else if (r_sum[scip_pkg::SUM_W-2])
                    begin
                        int_out_next = scip_pkg::INT_MAX;
                    end
                    else
                    begin
                        int_out_next = r_sum[scip_pkg::INT_W-1:0];
                    end
                    status_next = scip_pkg::STAT_OK;
                    done_next   = 1'b1;
                    state_next  = scip_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = scip_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= scip_pkg::ST_IDLE;
            count_reg   <= '0;
            any_pos_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            any_pos_reg <= any_pos_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_wl_reg  <= first_wl_next;
        first_int_reg <= first_int_next;
        last_wl_reg   <= last_wl_next;
        last_int_reg  <= last_int_next;
        q_wl_reg      <= q_wl_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        w1_reg        <= w1_next;
        i1_reg        <= i1_next;
        i0_reg        <= i0_next;
        dw_reg        <= dw_next;
        width_reg     <= width_next;
        dmag_reg      <= dmag_next;
        neg_reg       <= neg_next;
        prod_reg      <= prod_next;
        int_out_reg   <= int_out_next;
        status_reg    <= status_next;
    end

    assign busy          = (state_reg != scip_pkg::ST_IDLE);
    assign done          = done_reg;
    assign intensity_out = int_out_reg;
    assign status        = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // flag a result that turns a load away
    logic load_rejected;
    assign load_rejected = (status == scip_pkg::STAT_FULL)
                        || (status == scip_pkg::STAT_OUT_OF_ORDER);

    // a non-query beat always answers in the next cycle
    `SCIP_ASSERT_NEXT(a_quick_answer, start && !busy && req_type != scip_pkg::REQ_QUERY, done)

    // the search window never collapses before a read is issued
    `SCIP_ASSERT_SAME(a_search_window, state_reg == scip_pkg::ST_SRCH_RD, lo_reg < hi_reg)

    // the divider is only kicked when it is free
    `SCIP_ASSERT_SAME(a_div_free, div_start, !div_stat.busy)

    // rejected loads carry no intensity
    `SCIP_ASSERT_SAME(a_reject_zero, done && load_rejected, intensity_out == '0)

endmodule
